@@ design/dts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the DFA token scanner.
// Holds the character class map, the transition ROM and the result record.
// No dependencies.
package dts_pkg;

  localparam int MAX_LEXEME_DEF = 255;
  localparam int LINE_BITS_DEF  = 16;

  localparam int STATE_COUNT = 55;
  localparam int NUM_CLASSES = 27;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [5:0] state_t;
  typedef logic [4:0] class_t;
  typedef logic [3:0] kind_t;

  localparam state_t START_STATE = 6'd0;
  localparam state_t DEAD_STATE  = 6'd54;
  localparam state_t WORD_STATE  = 6'd10;
  localparam state_t TICK_STATE  = 6'd11;

  localparam class_t CLS_UNDERSCORE = 5'd0;
  localparam class_t CLS_UPPER_F    = 5'd1;
  localparam class_t CLS_ALPHA      = 5'd22;
  localparam class_t CLS_DIGIT      = 5'd23;
  localparam class_t CLS_OTHER      = 5'd24;
  localparam class_t CLS_SPACE      = 5'd25;
  localparam class_t CLS_NEWLINE    = 5'd26;
  localparam class_t NO_COL         = 5'd27;

  localparam kind_t KIND_UNKNOWN  = 4'd11;
  localparam kind_t KIND_BAD_CHAR = 4'd12;

  typedef enum logic [2:0] {
    RK_DEAD,
    RK_WORD,
    RK_IDENT,
    RK_HDR,
    RK_START
  } row_kind_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [7:0]  token_length;
    logic        length_overflow;
    logic [15:0] line_number;
    logic [7:0]  bad_character;
    logic        last;
  } dts_result_t;

  localparam state_t START_ROW [NUM_CLASSES] = '{
    6'd6, 6'd11, 6'd10, 6'd24, 6'd10, 6'd10, 6'd34, 6'd4, 6'd2, 6'd1, 6'd13, 6'd10,
    6'd16, 6'd10, 6'd46, 6'd19, 6'd10, 6'd35, 6'd10, 6'd41, 6'd10, 6'd10, 6'd10,
    6'd33, 6'd34, 6'd54, 6'd54
  };

  localparam row_kind_t ROW_KIND [STATE_COUNT] = '{
    RK_START, RK_HDR,   RK_DEAD,  RK_WORD,  RK_DEAD,  RK_DEAD,  RK_WORD,  RK_WORD,
    RK_WORD,  RK_DEAD,  RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT,
    RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT,
    RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_WORD,  RK_WORD,  RK_DEAD,  RK_DEAD,
    RK_DEAD,  RK_DEAD,  RK_DEAD,  RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT,
    RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT,
    RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_IDENT, RK_DEAD
  };

  localparam state_t ROW_FILL [STATE_COUNT] = '{
    6'd0,  6'd1,  6'd0,  6'd3,  6'd0,  6'd0,  6'd7,  6'd7,  6'd9,  6'd0,  6'd0,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd29, 6'd29, 6'd0,  6'd0,  6'd0,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };

  localparam class_t ROW_ECOL [STATE_COUNT] = '{
    5'd27, 5'd27, 5'd8,  5'd25, 5'd7,  5'd27, 5'd27, 5'd23, 5'd27, 5'd27, 5'd27,
    5'd2,  5'd27, 5'd2,  5'd11, 5'd27, 5'd13, 5'd14, 5'd27, 5'd16, 5'd10, 5'd3,
    5'd13, 5'd27, 5'd4,  5'd4,  5'd5,  5'd0,  5'd27, 5'd23, 5'd23, 5'd6,  5'd27,
    5'd23, 5'd27, 5'd13, 5'd11, 5'd18, 5'd17, 5'd2,  5'd27, 5'd17, 5'd13, 5'd20,
    5'd21, 5'd27, 5'd4,  5'd2,  5'd11, 5'd10, 5'd2,  5'd18, 5'd13, 5'd27, 5'd27
  };

  localparam state_t ROW_ETGT [STATE_COUNT] = '{
    6'd0,  6'd0,  6'd3,  6'd3,  6'd5,  6'd0,  6'd0,  6'd8,  6'd0,  6'd0,  6'd0,
    6'd12, 6'd0,  6'd14, 6'd15, 6'd0,  6'd17, 6'd18, 6'd0,  6'd20, 6'd21, 6'd22,
    6'd23, 6'd0,  6'd25, 6'd26, 6'd27, 6'd28, 6'd0,  6'd30, 6'd31, 6'd32, 6'd0,
    6'd33, 6'd0,  6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd0,  6'd42, 6'd43, 6'd44,
    6'd45, 6'd0,  6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd0,  6'd0
  };

  localparam kind_t ACCEPT_KIND [STATE_COUNT] = '{
    4'd11, 4'd0,  4'd11, 4'd1,  4'd11, 4'd2,  4'd11, 4'd11, 4'd11, 4'd3,  4'd11,
    4'd11, 4'd4,  4'd11, 4'd11, 4'd5,  4'd11, 4'd11, 4'd6,  4'd11, 4'd11, 4'd11,
    4'd11, 4'd7,  4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd8,
    4'd9,  4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd7,  4'd11, 4'd11, 4'd11,
    4'd11, 4'd7,  4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd7,  4'd11
  };

  function automatic class_t char_class(logic [7:0] b);
    class_t c;
    case (b)
      "_":   c = 5'd0;
      "F":   c = 5'd1;
      "n":   c = 5'd2;
      "l":   c = 5'd3;
      "o":   c = 5'd4;
      "p":   c = 5'd5;
      ":":   c = 5'd6;
      ".":   c = 5'd7;
      "/":   c = 5'd8;
      "#":   c = 5'd9;
      "i":   c = 5'd10;
      "t":   c = 5'd11;
      "d":   c = 5'd12;
      "e":   c = 5'd13;
      "c":   c = 5'd14;
      "w":   c = 5'd15;
      "h":   c = 5'd16;
      "r":   c = 5'd17;
      "u":   c = 5'd18;
      "b":   c = 5'd19;
      "a":   c = 5'd20;
      "k":   c = 5'd21;
      8'h00, 8'h09, 8'h0D, 8'h20: c = CLS_SPACE;
      8'h0A: c = CLS_NEWLINE;
      default: begin
        if (b inside {["A":"Z"], ["a":"z"]}) begin
          c = CLS_ALPHA;
        end else if (b inside {["0":"9"]}) begin
          c = CLS_DIGIT;
        end else begin
          c = CLS_OTHER;
        end
      end
    endcase
    return c;
  endfunction

  function automatic logic word_col(class_t c);
    return c inside {[5'd1:5'd5], [5'd10:5'd22]};
  endfunction

  function automatic state_t next_state(state_t s, class_t c);
    state_t nx;
    nx = DEAD_STATE;
    if (s < 6'(STATE_COUNT) && c < 5'(NUM_CLASSES)) begin
      if (c == ROW_ECOL[s]) begin
        nx = ROW_ETGT[s];
      end else begin
        case (ROW_KIND[s])
          RK_START: nx = START_ROW[c];
          RK_HDR:   nx = (c <= CLS_OTHER) ? ROW_FILL[s] : DEAD_STATE;
          RK_WORD:  nx = word_col(c) ? ROW_FILL[s] : DEAD_STATE;
          RK_IDENT: begin
            if (c == CLS_UPPER_F) begin
              nx = TICK_STATE;
            end else if (word_col(c)) begin
              nx = WORD_STATE;
            end else begin
              nx = DEAD_STATE;
            end
          end
          default:  nx = DEAD_STATE;
        endcase
      end
    end
    return nx;
  endfunction

endpackage

@@ design/dts_front.sv @@
`timescale 1ns / 1ps
// Front end of the token scanner: classifies each byte, steps the DFA and
// builds up to two result records per item. Depends on dts_pkg.
module dts_front import dts_pkg::*; #(
  parameter int MAX_LEXEME = MAX_LEXEME_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  source_byte,
  input  logic        end_of_input,
  output logic [1:0]  push_count,
  output dts_result_t res_first,
  output dts_result_t res_second
);

  localparam int CNT_W  = $clog2(MAX_LEXEME + 1);
  localparam int LEN_W  = (CNT_W > 9) ? CNT_W : 9;
  localparam int LINE_W = (LINE_BITS > 16) ? LINE_BITS : 16;

  state_t               scan_state, scan_state_next;
  logic [CNT_W-1:0]     lexeme_count, lexeme_count_next;
  logic                 overflow_seen, overflow_seen_next;
  logic [LINE_BITS-1:0] current_line, current_line_next;

  class_t              cls;
  state_t              step_nx, start_nx;
  logic                emit_pend, emit_bad, restart;
  logic [LEN_W-1:0]    len_ext;
  logic [LINE_W-1:0]   line_ext;
  logic [15:0]         line_out;
  dts_result_t         pend_res, bad_res;

  always_comb begin
    cls      = char_class(source_byte);
    step_nx  = next_state(scan_state, cls);
    start_nx = next_state(START_STATE, cls);

    len_ext  = LEN_W'(lexeme_count);
    line_ext = LINE_W'(current_line);
    line_out = (line_ext > LINE_W'(17'hFFFF)) ? 16'hFFFF : line_ext[15:0];

    pend_res.token_kind      = (scan_state < 6'(STATE_COUNT)) ? ACCEPT_KIND[scan_state]
                                                                : KIND_UNKNOWN;
    pend_res.token_length    = (len_ext > LEN_W'(9'd255)) ? 8'hFF : len_ext[7:0];
    pend_res.length_overflow = overflow_seen | (len_ext > LEN_W'(9'd255));
    pend_res.line_number     = line_out;
    pend_res.bad_character   = 8'd0;
    pend_res.last            = 1'b1;

    bad_res.token_kind      = KIND_BAD_CHAR;
    bad_res.token_length    = 8'd1;
    bad_res.length_overflow = 1'b0;
    bad_res.line_number     = line_out;
    bad_res.bad_character   = source_byte;
    bad_res.last            = 1'b1;

    scan_state_next    = scan_state;
    lexeme_count_next  = lexeme_count;
    overflow_seen_next = overflow_seen;
    current_line_next  = current_line;
    emit_pend          = 1'b0;
    emit_bad           = 1'b0;
    restart            = 1'b1;

    if (end_of_input) begin
      emit_pend          = (scan_state != START_STATE);
      scan_state_next    = START_STATE;
      lexeme_count_next  = '0;
      overflow_seen_next = 1'b0;
      current_line_next  = LINE_BITS'(1);
    end else begin
      if (scan_state != START_STATE) begin
        if (step_nx != DEAD_STATE) begin
          restart = 1'b0;
          scan_state_next = step_nx;
          if (lexeme_count < CNT_W'(MAX_LEXEME)) begin
            lexeme_count_next = lexeme_count + CNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
        end else begin
          emit_pend          = 1'b1;
          scan_state_next    = START_STATE;
          lexeme_count_next  = '0;
          overflow_seen_next = 1'b0;
        end
      end
      if (restart) begin
        if (cls == CLS_SPACE || cls == CLS_NEWLINE) begin
          if (cls == CLS_NEWLINE && current_line != {LINE_BITS{1'b1}}) begin
            current_line_next = current_line + LINE_BITS'(1);
          end
        end else if (start_nx == DEAD_STATE) begin
          emit_bad = 1'b1;
        end else begin
          scan_state_next    = start_nx;
          lexeme_count_next  = CNT_W'(1);
          overflow_seen_next = 1'b0;
        end
      end
    end

    res_first      = emit_pend ? pend_res : bad_res;
    res_first.last = ~(emit_pend & emit_bad);
    res_second     = bad_res;
    push_count     = accept ? {emit_pend & emit_bad, emit_pend ^ emit_bad} : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state    <= START_STATE;
      lexeme_count  <= '0;
      overflow_seen <= 1'b0;
      current_line  <= LINE_BITS'(1);
    end else if (accept) begin
      scan_state    <= scan_state_next;
      lexeme_count  <= lexeme_count_next;
      overflow_seen <= overflow_seen_next;
      current_line  <= current_line_next;
    end
  end

endmodule

@@ design/dts_queue.sv @@
`timescale 1ns / 1ps
// Result queue between scanner front and output stage: takes up to two
// records per cycle, gives one. Depends on dts_pkg.
module dts_queue import dts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  push_count,
  input  dts_result_t push_first,
  input  dts_result_t push_second,
  input  logic        pop,
  output dts_result_t head,
  output logic        not_empty,
  output logic        has_room
);

  dts_result_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign has_room  = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_count) - QCNT_W'(pop);
    end
  end

endmodule

@@ design/dts_back.sv @@
`timescale 1ns / 1ps
// Output stage of the token scanner: holds one result item on the output
// handshake and refills it from the queue. Depends on dts_pkg.
module dts_back import dts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dts_result_t head,
  input  logic        head_valid,
  output logic        pop,
  output logic        tok_valid,
  input  logic        tok_ready,
  output dts_result_t tok
);

  assign pop = head_valid & (~tok_valid | tok_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (~tok_valid | tok_ready) begin
      tok_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tok <= head;
    end
  end

endmodule

@@ design/dfa_token_scanner.sv @@
`timescale 1ns / 1ps
// Table-driven DFA token scanner. Accepts one source byte per clock and
// emits zero, one or two token items for it (a pending token cut off by the
// byte, then possibly a bad-character item). Results pass through a
// four-entry queue into a registered output stage. While tok_ready is high
// it gives one item per clock; the input takes a byte whenever the queue has
// two free slots, so a byte that causes one or no token sustains one item per
// cycle. A byte's first token passes a queue entry and the output register.
// No clearing pass after reset. Depends on dts_pkg, dts_front, dts_queue, dts_back.
module dfa_token_scanner import dts_pkg::*; #(
  parameter int MAX_LEXEME = MAX_LEXEME_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_ready,
  input  logic [7:0]  source_byte,
  input  logic        end_of_input,
  output logic        tok_valid,
  input  logic        tok_ready,
  output logic [3:0]  token_kind,
  output logic [7:0]  token_length,
  output logic        length_overflow,
  output logic [15:0] line_number,
  output logic [7:0]  bad_character,
  output logic        last
);

  logic        accept;
  logic [1:0]  push_count;
  dts_result_t res_first, res_second, head, tok;
  logic        not_empty, has_room, pop;

  assign src_ready = has_room;
  assign accept    = src_valid & has_room;

  dts_front #(
    .MAX_LEXEME (MAX_LEXEME),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .source_byte  (source_byte),
    .end_of_input (end_of_input),
    .push_count   (push_count),
    .res_first    (res_first),
    .res_second   (res_second)
  );

  dts_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (res_first),
    .push_second (res_second),
    .pop         (pop),
    .head        (head),
    .not_empty   (not_empty),
    .has_room    (has_room)
  );

  dts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok        (tok)
  );

  assign token_kind      = tok.token_kind;
  assign token_length    = tok.token_length;
  assign length_overflow = tok.length_overflow;
  assign line_number     = tok.line_number;
  assign bad_character   = tok.bad_character;
  assign last            = tok.last;

endmodule
